// ----- rtl/lat_pkg.sv -----
// Shared constants, codes and control types of the toroidal life engine.
`default_nettype none

package lat_pkg;

  // Default grid bounds.
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_ROWS_USED = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS_USED = 1'd1;
  localparam logic [CFG_W-1:0]     SIZE_RESET    = 7'd15;

  // Input item layout.
  localparam int REQ_W      = 2;
  localparam int COORD_W    = 6;
  localparam int IN_TDATA_W = 16;
  localparam logic [REQ_W-1:0] REQ_TOGGLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

  // Result item layout.
  localparam int GEN_W       = 32;
  localparam int OUT_TDATA_W = 40;

  // B3/S23 neighbor counts.
  localparam logic [3:0] LIFE_BIRTH   = 4'd3;
  localparam logic [3:0] LIFE_SURVIVE = 4'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;  // capture the clamped input item
    logic rd_item;    // read the addressed row
    logic rd_last;    // read the last row in use
    logic rd_first;   // read row zero, rewind the row counter
    logic ld_up;      // take read data as the row above
    logic ld_cur;     // take read data as the current row and keep a copy of row zero
    logic rd_dn;      // read the row below the current one
    logic wr_adv;     // write the next generation of the current row, advance
    logic wr_item;    // write back the row with the addressed cell flipped
    logic cap_res;    // capture the addressed cell as the result bit
    logic wr_clr;     // write a dead row during the clearing pass
    logic gen_inc;    // count one generation
    logic out_load;   // load the result register
  } lat_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic row_last;
    logic is_toggle;
    logic is_advance;
  } lat_sts_t;

endpackage

`default_nettype wire

// ----- rtl/lat_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module lat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lat_dp.sv -----
// Datapath: size registers, item capture, row store, row update logic and result register.
`default_nettype none

module lat_dp #(
  parameter int MAX_ROWS = lat_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lat_pkg::MAX_COLS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [lat_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [lat_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire  [lat_pkg::IN_TDATA_W-1:0]      in_tdata_i,
  input  wire  lat_pkg::lat_cmd_t             cmd_i,
  output lat_pkg::lat_sts_t                   sts_o,
  output logic [lat_pkg::OUT_TDATA_W-1:0]     out_tdata_o
);

  import lat_pkg::*;

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int PAD_W = OUT_TDATA_W - GEN_W - 1;

  logic [CFG_W-1:0]    rows_q, cols_q;
  logic [RAW-1:0]      lr, lc_row_unused_n;
  logic [CAW-1:0]      lc;
  logic [REQ_W-1:0]    in_req;
  logic [COORD_W-1:0]  in_row, in_col;
  logic [RAW-1:0]      row_cl;
  logic [CAW-1:0]      col_cl;
  logic [REQ_W-1:0]    req_q;
  logic [RAW-1:0]      row_q;
  logic [CAW-1:0]      col_q;
  logic [RAW-1:0]      r_q, r_d;
  logic [MAX_COLS-1:0] up_q, cur_q, save_q, dn_row, nrow, rd_data, wdata, col_mask;
  logic [MAX_COLS+1:0] up_x, cur_x, dn_x;
  logic                rd_en, wr_en;
  logic [RAW-1:0]      rd_addr, wr_addr;
  logic                res_q;
  logic [GEN_W-1:0]    gen_q;

  assign lc_row_unused_n = '0;

  // Size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIZE_RESET;
      cols_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS_USED: rows_q <= cfg_wdata_i;
        REG_COLS_USED: cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Last row and column in use: zero acts as one, oversize acts as the bound.
  always_comb begin
    if (rows_q == '0) begin
      lr = '0;
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      lr = RAW'(MAX_ROWS - 1);
    end else begin
      lr = RAW'(rows_q - 1'b1);
    end
    if (cols_q == '0) begin
      lc = '0;
    end else if (32'(cols_q) > 32'(MAX_COLS)) begin
      lc = CAW'(MAX_COLS - 1);
    end else begin
      lc = CAW'(cols_q - 1'b1);
    end
  end

  assign in_req = in_tdata_i[1:0];
  assign in_row = in_tdata_i[7:2];
  assign in_col = in_tdata_i[13:8];

  assign row_cl = (32'(in_row) > 32'(lr)) ? lr : RAW'(in_row);
  assign col_cl = (32'(in_col) > 32'(lc)) ? lc : CAW'(in_col);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      req_q <= in_req;
      row_q <= row_cl;
      col_q <= col_cl;
    end
  end

  // Row counter for the clearing pass and the generation sweep.
  always_comb begin
    r_d = r_q;
    if (cmd_i.rd_first) begin
      r_d = '0;
    end else if (cmd_i.wr_adv || cmd_i.wr_clr) begin
      r_d = r_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else begin
      r_q <= r_d;
    end
  end

  // Row store read side.
  assign rd_en = cmd_i.rd_item | cmd_i.rd_last | cmd_i.rd_first | cmd_i.rd_dn;

  always_comb begin
    rd_addr = '0;
    if (cmd_i.rd_item) begin
      rd_addr = row_q;
    end else if (cmd_i.rd_last) begin
      rd_addr = lr;
    end else if (cmd_i.rd_dn) begin
      rd_addr = (r_q == lr) ? '0 : r_q + 1'b1;
    end
  end

  // The row below the last one is the original row zero, already overwritten in the store.
  assign dn_row = (r_q == lr) ? save_q : rd_data;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_up) begin
      up_q <= rd_data;
    end
    if (cmd_i.ld_cur) begin
      cur_q  <= rd_data;
      save_q <= rd_data;
    end
    if (cmd_i.wr_adv) begin
      up_q  <= cur_q;
      cur_q <= dn_row;
    end
  end

  // Rows extended with their wrap neighbors: bit c is left of column c, bit c+2 right of it.
  assign up_x  = {up_q[0],  up_q,  up_q[lc]};
  assign cur_x = {cur_q[0], cur_q, cur_q[lc]};
  assign dn_x  = {dn_row[0], dn_row, dn_row[lc]};

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    logic       at_wrap;
    logic       up_r, cur_r, dn_r;
    logic [3:0] cnt;

    assign at_wrap = (CAW'(c) == lc);
    assign up_r    = at_wrap ? up_q[0]   : up_x[c+2];
    assign cur_r   = at_wrap ? cur_q[0]  : cur_x[c+2];
    assign dn_r    = at_wrap ? dn_row[0] : dn_x[c+2];

    assign cnt = {3'b0, up_x[c]}  + {3'b0, up_q[c]}   + {3'b0, up_r}
               + {3'b0, cur_x[c]} + {3'b0, cur_r}
               + {3'b0, dn_x[c]}  + {3'b0, dn_row[c]} + {3'b0, dn_r};

    // Columns outside the region keep their value.
    assign nrow[c] = (CAW'(c) > lc) ? cur_q[c]
                   : ((cnt == LIFE_BIRTH) | (cur_q[c] & (cnt == LIFE_SURVIVE)));
  end

  // Row store write side.
  assign col_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << col_q;
  assign wr_en    = cmd_i.wr_clr | cmd_i.wr_adv | cmd_i.wr_item;
  assign wr_addr  = cmd_i.wr_item ? row_q : r_q;

  always_comb begin
    wdata = '0;
    if (cmd_i.wr_adv) begin
      wdata = nrow;
    end else if (cmd_i.wr_item) begin
      wdata = rd_data ^ col_mask;
    end
  end

  lat_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Result bit, generation counter and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_res) begin
      res_q <= rd_data[col_q] ^ sts_o.is_toggle;
    end
    if (cmd_i.out_load) begin
      out_tdata_o <= {PAD_W'(lc_row_unused_n), gen_q, res_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cmd_i.gen_inc) begin
      gen_q <= gen_q + 1'b1;
    end
  end

  assign sts_o.clr_last   = (r_q == RAW'(MAX_ROWS - 1));
  assign sts_o.row_last   = (r_q == lr);
  assign sts_o.is_toggle  = (req_q == REQ_TOGGLE);
  assign sts_o.is_advance = (req_q == REQ_ADVANCE);

endmodule

`default_nettype wire

// ----- rtl/lat_ctrl.sv -----
// Controller: sequences the clearing pass, cell access, the generation sweep and the handshakes.
`default_nettype none

module lat_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  input  wire  lat_pkg::lat_sts_t sts_i,
  output lat_pkg::lat_cmd_t  cmd_o
);

  import lat_pkg::*;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ISSUE   = 4'd2;
  localparam logic [3:0] S_ADV_UP  = 4'd3;
  localparam logic [3:0] S_ADV_CUR = 4'd4;
  localparam logic [3:0] S_ADV_DN  = 4'd5;
  localparam logic [3:0] S_ADV_WR  = 4'd6;
  localparam logic [3:0] S_POST    = 4'd7;
  localparam logic [3:0] S_RD      = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts_i.is_advance) begin
          cmd_o.rd_last = 1'b1;
          state_d = S_ADV_UP;
        end else begin
          cmd_o.rd_item = 1'b1;
          state_d = S_RD;
        end
      end
      S_ADV_UP: begin
        cmd_o.ld_up    = 1'b1;
        cmd_o.rd_first = 1'b1;
        state_d = S_ADV_CUR;
      end
      S_ADV_CUR: begin
        cmd_o.ld_cur = 1'b1;
        state_d = S_ADV_DN;
      end
      S_ADV_DN: begin
        cmd_o.rd_dn = 1'b1;
        state_d = S_ADV_WR;
      end
      S_ADV_WR: begin
        cmd_o.wr_adv = 1'b1;
        if (sts_i.row_last) begin
          cmd_o.gen_inc = 1'b1;
          state_d = S_POST;
        end else begin
          state_d = S_ADV_DN;
        end
      end
      S_POST: begin
        cmd_o.rd_item = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.cap_res = 1'b1;
        cmd_o.wr_item = sts_i.is_toggle;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.rd_item, cmd_o.rd_last, cmd_o.rd_first, cmd_o.rd_dn}))
    else $error("more than one row read issued in a cycle");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.wr_clr, cmd_o.wr_adv, cmd_o.wr_item}))
    else $error("more than one row write issued in a cycle");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still held");

  a_gen_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.gen_inc |-> (cmd_o.wr_adv && sts_i.row_last))
    else $error("generation counted outside the last row write");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> ($past(in_ready_o) == 1'b0))
    else $error("input accepted during the clearing pass");

endmodule

`default_nettype wire

// ----- rtl/life_automaton_torus.sv -----
// Top level of the toroidal B3/S23 life engine.
//
// Usage:
//  - Input items arrive on s_axis_*; each carries a request (toggle, read or
//    advance one generation) and a row and column, clamped to the region in use.
//  - Every item returns one result on m_axis_*: the addressed cell after the
//    operation and the number of generations advanced since reset.
//  - rows_used and cols_used are set through cfg_we_i / cfg_idx_i / cfg_wdata_i;
//    write them only while no item is in flight. Zero acts as one, values above
//    the grid bound act as the bound.
//  - For toggle and read the addressed row is read, the result bit captured and,
//    for toggle, the flipped row written back before m_axis_tvalid rises. An
//    advance first reads the last row and row zero, then sweeps the rows in use
//    in turn through the single read port of the row store, reading the row below
//    and writing the next generation of the current row, before it reads the
//    addressed cell; all cells of a row are updated at once.
//  - One item is in work at a time; the next transfer is taken as soon as the
//    result sits in the output register, even while the receiver stalls. A stalled
//    result holds the block in its final step until the output register frees.
//  - After reset the row store is cleared one row per cycle, all MAX_ROWS rows, with
//    s_axis_tready low; configuration writes are taken during that pass.
`default_nettype none

module life_automaton_torus #(
  parameter int MAX_ROWS = lat_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lat_pkg::MAX_COLS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration write port: index 0 rows_used, index 1 cols_used.
  input  wire                              cfg_we_i,
  input  wire  [lat_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [lat_pkg::CFG_W-1:0]        cfg_wdata_i,
  // Request stream.
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [lat_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // req_type[1:0], row[7:2], col[13:8]
  // Result stream.
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [lat_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // cell_state[0], generation_count[32:1]
);

  import lat_pkg::*;

  lat_cmd_t cmd;
  lat_sts_t sts;

  // Sequence each item and own both handshakes.
  lat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the grid, the sizes, the generation counter and the result register.
  lat_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_tdata_o (m_axis_tdata)
  );

endmodule

`default_nettype wire
